// File: rtl/mlfq_pkg.sv
// Shared types, codes and widths for the multilevel feedback queue scheduler.
// Used by every module of the block; depends on nothing.
package mlfq_pkg;

    // Table size default
    localparam int SLOTS_DEFAULT = 64;

    // Field widths
    localparam int OP_W         = 2;
    localparam int SLOT_FIELD_W = 6;
    localparam int STATE_W      = 3;
    localparam int REQ_LEVEL_W  = 4;
    localparam int LEVEL_W      = 3;
    localparam int BUDGET_W     = 16;
    localparam int TICK_W       = 32;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_BUDGET    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_INTERVAL = 2'd2;

    // Configuration reset values
    localparam logic [LEVEL_W-1:0]  MAX_LEVEL_RST      = 3'd2;
    localparam logic [BUDGET_W-1:0] FULL_BUDGET_RST    = 16'd10;
    localparam logic [TICK_W-1:0]   BOOST_INTERVAL_RST = 32'd100;

    // A pick gives up after this many passes in a row that find nothing
    localparam int             EMPTY_W          = 4;
    localparam logic [EMPTY_W-1:0] EMPTY_PASS_LIMIT = 4'd9;

    // Task life states
    localparam logic [STATE_W-1:0] TS_EMBRYO   = 3'd1;
    localparam logic [STATE_W-1:0] TS_RUNNABLE = 3'd3;
    localparam logic [STATE_W-1:0] TS_RUNNING  = 3'd4;
    localparam logic [STATE_W-1:0] TS_ZOMBIE   = 3'd5;

    typedef enum logic [OP_W-1:0] {
        OP_SET_STATE = 2'd0,
        OP_SET_PRIO  = 2'd1,
        OP_PICK      = 2'd2,
        OP_ACCOUNT   = 2'd3
    } op_t;

    // One entry of the slot table
    typedef struct packed {
        logic [STATE_W-1:0]  state;
        logic [LEVEL_W-1:0]  level;
        logic [BUDGET_W-1:0] budget;
    } slot_entry_t;

    // Read address source of the slot table
    typedef enum logic [1:0] {
        RD_SLOT  = 2'd0,
        RD_SCAN  = 2'd1,
        RD_SWEEP = 2'd2
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SLOT_UPD,
        S_BOOST_RD,
        S_BOOST_WR,
        S_FINAL_RD,
        S_FINAL_CAP,
        S_PICK_POS,
        S_PICK_EVAL,
        S_RESULT
    } fsm_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;
        rd_sel_t rd_sel;
        logic    pick_start;
        logic    slot_update;
        logic    res_zero;
        logic    boost_start;
        logic    sweep_write;
        logic    final_cap;
        logic    pass_advance;
        logic    pick_idle;
        logic    pick_eval;
        logic    load_out;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t  op;
        logic slot_in_range;
        logic boost_due;
        logic sweep_last;
        logic pass_end;
        logic pass_exhausted;
        logic pick_hit;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/mlfq_ctrl.sv
// Sequencing controller of the scheduler: one state machine that steps the
// datapath through each word. Depends on mlfq_pkg.
module mlfq_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mlfq_pkg::dp_status_t status,
    output mlfq_pkg::ctrl_cmd_t  cmd
);
    import mlfq_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (status.op == OP_PICK) begin
                    state_next = S_PICK_POS;
                end else if (!status.slot_in_range) begin
                    state_next = S_RESULT;
                end else begin
                    state_next = S_SLOT_UPD;
                end
            end
            S_SLOT_UPD: begin
                if (status.op == OP_ACCOUNT && status.boost_due) begin
                    state_next = S_BOOST_RD;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_BOOST_RD: state_next = S_BOOST_WR;
            S_BOOST_WR: begin
                state_next = status.sweep_last ? S_FINAL_RD : S_BOOST_RD;
            end
            S_FINAL_RD:  state_next = S_FINAL_CAP;
            S_FINAL_CAP: state_next = S_RESULT;
            S_PICK_POS: begin
                if (status.pass_end) begin
                    if (status.pass_exhausted) state_next = S_RESULT;
                end else begin
                    state_next = S_PICK_EVAL;
                end
            end
            S_PICK_EVAL: begin
                state_next = status.pick_hit ? S_RESULT : S_PICK_POS;
            end
            S_RESULT: begin
                if (status.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd      = '0;
        cmd.rd_sel = RD_SLOT;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DISPATCH: begin
                cmd.pick_start = (status.op == OP_PICK);
                cmd.res_zero   = (status.op != OP_PICK) && !status.slot_in_range;
            end
            S_SLOT_UPD: begin
                cmd.slot_update = 1'b1;
                cmd.boost_start = (status.op == OP_ACCOUNT) && status.boost_due;
            end
            S_BOOST_RD: cmd.rd_sel = RD_SWEEP;
            S_BOOST_WR: cmd.sweep_write = 1'b1;
            S_FINAL_RD: cmd.rd_sel = RD_SLOT;
            S_FINAL_CAP: cmd.final_cap = 1'b1;
            S_PICK_POS: begin
                cmd.rd_sel = RD_SCAN;
                if (status.pass_end) begin
                    cmd.pass_advance = 1'b1;
                    cmd.pick_idle    = status.pass_exhausted;
                    cmd.res_zero     = status.pass_exhausted;
                end
            end
            S_PICK_EVAL: cmd.pick_eval = 1'b1;
            S_RESULT: cmd.load_out = status.out_free;
            default: ;
        endcase
    end

endmodule

// File: rtl/mlfq_dpath.sv
// Datapath of the scheduler: slot table memory with valid bits, scan and
// boost registers, configuration registers and the result register.
// Depends on mlfq_pkg; driven by mlfq_ctrl.
module mlfq_dpath #(
    parameter int SLOTS = mlfq_pkg::SLOTS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [mlfq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mlfq_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [mlfq_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  mlfq_pkg::ctrl_cmd_t              cmd,
    output mlfq_pkg::dp_status_t             status
);
    import mlfq_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int POS_W  = $clog2(SLOTS + 1);

    // Configuration registers
    logic [LEVEL_W-1:0]  max_level_reg;
    logic [BUDGET_W-1:0] full_budget_reg;
    logic [TICK_W-1:0]   boost_interval_reg;

    // Captured input word
    op_t                     in_op_reg;
    logic [SLOT_FIELD_W-1:0] in_slot_reg;
    logic [STATE_W-1:0]      in_state_reg;
    logic [REQ_LEVEL_W-1:0]  in_level_reg;
    logic [BUDGET_W-1:0]     in_ran_reg;
    logic [TICK_W-1:0]       in_now_reg;

    // Slot table
    slot_entry_t      slot_mem_reg [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    slot_entry_t      rd_data_reg;
    logic             rd_valid_reg;
    slot_entry_t      eff_entry;

    // Scan, boost and sweep state
    logic [LEVEL_W-1:0] scan_level_reg;
    logic [POS_W-1:0]   scan_pos_reg;
    logic               found_reg;
    logic [EMPTY_W-1:0] empty_reg;
    logic [TICK_W-1:0]  deadline_reg;
    logic [SLOT_W-1:0]  sweep_idx_reg;

    // Pending result fields
    logic [SLOT_FIELD_W-1:0] res_chosen_reg;
    logic                    res_valid_reg;
    logic                    res_status_reg;
    logic [LEVEL_W-1:0]      res_level_reg;
    logic [BUDGET_W-1:0]     res_budget_reg;
    logic                    res_demoted_reg;
    logic                    res_boosted_reg;

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [SLOT_W-1:0] slot_idx;
    logic [SLOT_W-1:0] scan_idx;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_addr;
    logic              wr_en;
    slot_entry_t       wr_data;
    slot_entry_t       upd_entry;
    logic              upd_status;
    logic              upd_demoted;
    slot_entry_t       boost_entry;
    slot_entry_t       pick_entry;
    logic              pick_hit;

    assign slot_idx = SLOT_W'(in_slot_reg);
    assign scan_idx = scan_pos_reg[SLOT_W-1:0];

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_level_reg      <= MAX_LEVEL_RST;
            full_budget_reg    <= FULL_BUDGET_RST;
            boost_interval_reg <= BOOST_INTERVAL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_MAX_LEVEL:      max_level_reg      <= cfg_wr_data[LEVEL_W-1:0];
                CFG_FULL_BUDGET:    full_budget_reg    <= cfg_wr_data[BUDGET_W-1:0];
                CFG_BOOST_INTERVAL: boost_interval_reg <= cfg_wr_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted word, op in the lowest bits
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_op_reg    <= op_t'(s_tdata[1:0]);
            in_slot_reg  <= s_tdata[7:2];
            in_state_reg <= s_tdata[10:8];
            in_level_reg <= s_tdata[14:11];
            in_ran_reg   <= s_tdata[30:15];
            in_now_reg   <= s_tdata[62:31];
        end
    end

    // Select read address
    always_comb begin
        case (cmd.rd_sel)
            RD_SLOT:  rd_addr = slot_idx;
            RD_SCAN:  rd_addr = scan_idx;
            RD_SWEEP: rd_addr = sweep_idx_reg;
            default:  rd_addr = slot_idx;
        endcase
    end

    // Table memory: one write and one registered read a cycle
    always_ff @(posedge aclk) begin
        if (wr_en) slot_mem_reg[wr_addr] <= wr_data;
        rd_data_reg  <= slot_mem_reg[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    // Mark entries written since reset; others read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign eff_entry = rd_valid_reg ? rd_data_reg : '0;

    // Update of the addressed slot
    always_comb begin
        upd_entry   = eff_entry;
        upd_status  = 1'b0;
        upd_demoted = 1'b0;
        case (in_op_reg)
            OP_SET_STATE: begin
                if (in_state_reg <= TS_ZOMBIE) begin
                    upd_entry.state = in_state_reg;
                    if (in_state_reg == TS_EMBRYO) begin
                        upd_entry.level  = max_level_reg;
                        upd_entry.budget = full_budget_reg;
                    end
                end
            end
            OP_SET_PRIO: begin
                if (in_level_reg > {1'b0, max_level_reg}) begin
                    upd_status = 1'b1;
                end else begin
                    upd_entry.level  = in_level_reg[LEVEL_W-1:0];
                    upd_entry.budget = full_budget_reg;
                end
            end
            OP_ACCOUNT: begin
                if (in_ran_reg >= eff_entry.budget) begin
                    if (eff_entry.level != '0) begin
                        upd_entry.level = eff_entry.level - 1'b1;
                        upd_demoted     = 1'b1;
                    end
                    upd_entry.budget = full_budget_reg;
                end else begin
                    upd_entry.budget = eff_entry.budget - in_ran_reg;
                end
            end
            default: ;
        endcase
    end

    // Raise one entry during the boost sweep
    always_comb begin
        boost_entry = eff_entry;
        if (eff_entry.state != TS_ZOMBIE && eff_entry.level < max_level_reg) begin
            boost_entry.level  = eff_entry.level + 1'b1;
            boost_entry.budget = full_budget_reg;
        end
    end

    // Pick test of the scanned entry
    assign pick_hit = (eff_entry.state == TS_RUNNABLE) && (eff_entry.level == scan_level_reg);
    always_comb begin
        pick_entry       = eff_entry;
        pick_entry.state = TS_RUNNING;
    end

    // Select write source
    always_comb begin
        wr_en   = cmd.slot_update | cmd.sweep_write | (cmd.pick_eval & pick_hit);
        wr_addr = scan_idx;
        wr_data = pick_entry;
        if (cmd.slot_update) begin
            wr_addr = slot_idx;
            wr_data = upd_entry;
        end else if (cmd.sweep_write) begin
            wr_addr = sweep_idx_reg;
            wr_data = boost_entry;
        end
    end

    // Advance the scan, the boost deadline and the sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_level_reg <= MAX_LEVEL_RST;
            scan_pos_reg   <= '0;
            found_reg      <= 1'b0;
            empty_reg      <= '0;
            deadline_reg   <= BOOST_INTERVAL_RST;
            sweep_idx_reg  <= '0;
        end else begin
            if (cmd.pick_start) empty_reg <= '0;
            // Give up: restart the scan at the top
            if (cmd.pick_idle) begin
                scan_level_reg <= max_level_reg;
                scan_pos_reg   <= '0;
                found_reg      <= 1'b0;
            end else if (cmd.pass_advance) begin
                if (!found_reg) begin
                    empty_reg      <= empty_reg + 1'b1;
                    scan_level_reg <= (scan_level_reg == '0) ? max_level_reg
                                                             : scan_level_reg - 1'b1;
                end
                found_reg    <= 1'b0;
                scan_pos_reg <= '0;
            end else if (cmd.pick_eval) begin
                scan_pos_reg <= scan_pos_reg + 1'b1;
                if (pick_hit) found_reg <= 1'b1;
            end
            if (cmd.boost_start) begin
                deadline_reg  <= in_now_reg + boost_interval_reg;
                sweep_idx_reg <= '0;
            end
            if (cmd.sweep_write) sweep_idx_reg <= sweep_idx_reg + 1'b1;
        end
    end

    // Build the pending result
    always_ff @(posedge aclk) begin
        if (cmd.res_zero) begin
            res_chosen_reg  <= '0;
            res_valid_reg   <= 1'b0;
            res_status_reg  <= 1'b0;
            res_level_reg   <= '0;
            res_budget_reg  <= '0;
            res_demoted_reg <= 1'b0;
            res_boosted_reg <= 1'b0;
        end
        if (cmd.slot_update) begin
            res_chosen_reg  <= '0;
            res_valid_reg   <= 1'b0;
            res_status_reg  <= upd_status;
            res_level_reg   <= upd_entry.level;
            res_budget_reg  <= upd_entry.budget;
            res_demoted_reg <= upd_demoted;
            res_boosted_reg <= cmd.boost_start;
        end
        if (cmd.final_cap) begin
            res_level_reg  <= eff_entry.level;
            res_budget_reg <= eff_entry.budget;
        end
        if (cmd.pick_eval && pick_hit) begin
            res_chosen_reg  <= SLOT_FIELD_W'(scan_idx);
            res_valid_reg   <= 1'b1;
            res_status_reg  <= 1'b0;
            res_level_reg   <= eff_entry.level;
            res_budget_reg  <= eff_entry.budget;
            res_demoted_reg <= 1'b0;
            res_boosted_reg <= 1'b0;
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= {3'b000, res_boosted_reg, res_demoted_reg, res_budget_reg,
                             res_level_reg, res_status_reg, res_valid_reg, res_chosen_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    // Status to the controller
    assign status.op             = in_op_reg;
    assign status.slot_in_range  = 32'(in_slot_reg) < 32'(SLOTS);
    assign status.boost_due      = deadline_reg <= in_now_reg;
    assign status.sweep_last     = sweep_idx_reg == SLOT_W'(SLOTS - 1);
    assign status.pass_end       = scan_pos_reg >= POS_W'(SLOTS);
    assign status.pass_exhausted = !found_reg && (empty_reg == EMPTY_PASS_LIMIT - 1'b1);
    assign status.pick_hit       = pick_hit;
    assign status.out_free       = !m_tvalid_reg || m_tready;

endmodule

// File: rtl/mlfq_process_scheduler.sv
// Top level of the multilevel feedback queue scheduler: controller plus
// datapath. Depends on mlfq_pkg, mlfq_ctrl and mlfq_dpath.
//
// Multilevel feedback queue scheduler over SLOTS task slots, one result word
// for every input word. The slot table is a single-port-write memory with a
// registered read, so all work goes one table access per step. After
// acceptance, set_state, set_priority and an account without boost update
// the slot and go to the result, an out-of-range slot goes straight to it;
// an account that triggers the boost sweeps the table one slot at a time
// (read, then write) and then rereads the addressed slot; a pick reads and
// then tests one slot at a time, pass by pass and level by level, and
// ends at the first hit or reports idle when nothing is runnable (the rest
// of a pass that already found a slot, then nine empty passes).
// A new word is accepted once the current one has moved into the output
// register, which holds it until it is taken. Configuration writes take
// effect at the next clock and are meant for times when no word is in flight.
module mlfq_process_scheduler #(
    parameter int SLOTS = mlfq_pkg::SLOTS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: op[1:0], slot[7:2], new_state[10:8], level[14:11],
    //          ran_ticks[30:15], now[62:31], zero[63]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mlfq_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: chosen_slot[5:0], chosen_valid[6], status[7], slot_level[10:8],
    //          slot_budget[26:11], demoted[27], boosted[28], zero[31:29]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mlfq_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [mlfq_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import mlfq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    mlfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mlfq_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// File: rtl/mlfq_checker.sv
// Port-level checks of the scheduler and the bind that attaches them.
// Depends on mlfq_pkg and mlfq_process_scheduler.
module mlfq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mlfq_pkg::M_TDATA_W-1:0] m_tdata
);

    // Hold a stalled result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // No accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // A successful pick carries no status, demotion or boost flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> !m_tdata[7] && !m_tdata[27] && !m_tdata[28])
        else $error("pick result carries flags of another op");

    // No chosen slot without chosen_valid; rejected priority never demotes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[6] |-> (m_tdata[5:0] == 6'd0) && !(m_tdata[7] && m_tdata[27]))
        else $error("inconsistent result flags");

endmodule

bind mlfq_process_scheduler mlfq_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
